// ===== design/rbp_pkg.sv =====
// ---------------------------------------------------------------------------
// rbp_pkg - range block partition shared definitions
// Request and response types, status codes and sequencer states.
// ---------------------------------------------------------------------------
package rbp_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int COUNT_WIDTH = 16;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_TOO_MANY = 2'd1;
	localparam logic [1:0] STATUS_BAD      = 2'd2;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] range_low;
		logic signed [COORD_WIDTH-1:0] range_high;
		logic [COUNT_WIDTH-1:0]        part_index;
		logic [COUNT_WIDTH-1:0]        part_count;
	} rbp_req_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] part_low;
		logic signed [COORD_WIDTH-1:0] part_high;
		logic [1:0]                    status;
	} rbp_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FIX,
		ST_MUL,
		ST_SUM,
		ST_OUT
	} rbp_state_t;

endpackage

// ===== design/range_block_partition.sv =====
// ---------------------------------------------------------------------------
// range_block_partition - 1-D block partition of an inclusive range
// Splits a coordinate range into part_count near-equal parts and returns
// the sub-range of part_index, using one restoring divider and a multiplier.
// ---------------------------------------------------------------------------
// Sequence: CHECK, DIV, FIX, MUL, SUM, OUT, then the registered done strobe;
// an error ends at CHECK. A new request is taken only when idle; the bit-serial
// divider produces one quotient bit per cycle, COORD_WIDTH bits in all.
// Results are shown for one cycle on done; the receiver cannot stall.
// Reset clears the sequencer and the strobe; no clearing pass.
module range_block_partition (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rbp_pkg::rbp_req_t req,
	output logic              done,
	output rbp_pkg::rbp_rsp_t rsp
);

	localparam int W     = rbp_pkg::COORD_WIDTH;
	localparam int CW    = rbp_pkg::COUNT_WIDTH;
	localparam int CNT_W = $clog2(W);
	localparam int CMP_W = W + CW;

	rbp_pkg::rbp_state_t state_q, state_d;
	rbp_pkg::rbp_req_t   req_q;
	rbp_pkg::rbp_rsp_t   rsp_q;
	logic                done_q;

	logic [W-1:0]     dq_q;
	logic [CW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W:0]       q_q;
	logic [CW-1:0]    first_q;
	logic [CW-1:0]    extra_q;
	logic [W:0]       size_q;
	logic [W-1:0]     prod_q;
	logic [W-1:0]     start_q;

	logic             accept;
	logic [W-1:0]     span;
	logic             bad;
	logic             too_many;
	logic [CW:0]      trial;
	logic             trial_ge;
	logic [CW:0]      rem_inc;
	logic             wrap;
	logic [CW-1:0]    rem_fix;
	logic [W+CW-1:0]  prod_full;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rbp_pkg::ST_IDLE:  if (start) state_d = rbp_pkg::ST_CHECK;
			rbp_pkg::ST_CHECK: state_d = (bad || too_many) ? rbp_pkg::ST_IDLE : rbp_pkg::ST_DIV;
			rbp_pkg::ST_DIV:   if (cnt_q == '0) state_d = rbp_pkg::ST_FIX;
			rbp_pkg::ST_FIX:   state_d = rbp_pkg::ST_MUL;
			rbp_pkg::ST_MUL:   state_d = rbp_pkg::ST_SUM;
			rbp_pkg::ST_SUM:   state_d = rbp_pkg::ST_OUT;
			rbp_pkg::ST_OUT:   state_d = rbp_pkg::ST_IDLE;
			default:           state_d = rbp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy   = (state_q != rbp_pkg::ST_IDLE);
		accept = start && !busy;
	end

	always_comb begin
		span     = req_q.range_high - req_q.range_low;
		bad      = (req_q.range_low > req_q.range_high) || (req_q.part_count == '0) ||
		           (req_q.part_index >= req_q.part_count);
		too_many = CMP_W'(span) < (CMP_W'(req_q.part_count) - CMP_W'(1));
		trial    = {rem_q, dq_q[W-1]};
		trial_ge = trial >= {1'b0, req_q.part_count};
		rem_inc  = {1'b0, rem_q} + (CW+1)'(1);
		wrap     = (rem_inc == {1'b0, req_q.part_count});
		rem_fix  = wrap ? '0 : rem_inc[CW-1:0];
		prod_full = W'(q_q[W-1:0]) * req_q.part_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbp_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == rbp_pkg::ST_CHECK) && (bad || too_many)) ||
			           (state_q == rbp_pkg::ST_OUT);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		case (state_q)
			rbp_pkg::ST_CHECK: begin
				dq_q  <= span;
				rem_q <= '0;
				cnt_q <= CNT_W'(W - 1);
				if (bad || too_many) begin
					rsp_q.part_low  <= '0;
					rsp_q.part_high <= '0;
					rsp_q.status    <= bad ? rbp_pkg::STATUS_BAD : rbp_pkg::STATUS_TOO_MANY;
				end
			end
			rbp_pkg::ST_DIV: begin
				rem_q <= trial_ge ? CW'(trial - {1'b0, req_q.part_count}) : trial[CW-1:0];
				dq_q  <= {dq_q[W-2:0], trial_ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			rbp_pkg::ST_FIX: begin
				q_q     <= {1'b0, dq_q} + (W+1)'(wrap);
				first_q <= req_q.part_count - rem_fix;
			end
			rbp_pkg::ST_MUL: begin
				prod_q  <= prod_full[W-1:0];
				extra_q <= (req_q.part_index > first_q) ? (req_q.part_index - first_q) : '0;
				size_q  <= q_q + (W+1)'(req_q.part_index >= first_q);
			end
			rbp_pkg::ST_SUM: begin
				start_q <= req_q.range_low + prod_q + W'(extra_q);
			end
			rbp_pkg::ST_OUT: begin
				rsp_q.part_low  <= start_q;
				rsp_q.part_high <= start_q + size_q[W-1:0] - W'(1);
				rsp_q.status    <= rbp_pkg::STATUS_OK;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
